[hdl/multilevel_priority_queue_core_macros.svh]
// Assertion macros for the multilevel priority queue checker.
// No dependencies; included by the checker file only.
`ifndef MULTILEVEL_PRIORITY_QUEUE_CORE_MACROS_SVH
`define MULTILEVEL_PRIORITY_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MLPQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mlpq checker: property failed");

// Next-cycle implication, disabled while reset is asserted.
`define MLPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mlpq checker: property failed");

`endif

[hdl/mlpq_pkg.sv]
// Package for the multilevel priority queue: sizes, function codes, beat types,
// and address helpers. No dependencies.
package mlpq_pkg;

	localparam int NUM_LEVELS  = 8;
	localparam int QUEUE_DEPTH = 16;
	localparam int ID_WIDTH    = 16;

	localparam int LVL_W   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int TOTAL_W = $clog2(NUM_LEVELS * QUEUE_DEPTH + 1);
	localparam int ADDR_W  = $clog2(NUM_LEVELS * QUEUE_DEPTH);
	localparam int ENTRIES = NUM_LEVELS * QUEUE_DEPTH;

	// Fixed field widths of the beats
	localparam int FUNC_W = 2;
	localparam int TID_W  = 16;
	localparam int PRIO_W = 4;
	localparam int TCNT_W = 8;
	localparam int LCNT_W = 5;

	localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_PEEK   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [TID_W-1:0]  task_id;
		logic [PRIO_W-1:0] priority_req;
	} req_t;

	typedef struct packed {
		logic [TID_W-1:0]  out_task_id;
		logic [PRIO_W-1:0] out_priority;
		logic              found;
		logic              rejected;
		logic              is_empty;
		logic [TCNT_W-1:0] total_count;
		logic [LCNT_W-1:0] level_count;
	} rsp_t;

	// Result fields known at accept time; the task id follows from the store
	typedef struct packed {
		logic [PRIO_W-1:0] out_priority;
		logic              found;
		logic              rejected;
		logic              is_empty;
		logic [TCNT_W-1:0] total_count;
		logic [LCNT_W-1:0] level_count;
	} meta_t;

	// Store access request: one write and one read port
	typedef struct packed {
		logic                we;
		logic [ADDR_W-1:0]   waddr;
		logic [ID_WIDTH-1:0] wdata;
		logic                re;
		logic [ADDR_W-1:0]   raddr;
	} mem_req_t;

	function automatic logic [ADDR_W-1:0] entry_addr(input logic [LVL_W-1:0] lvl,
			input logic [PTR_W-1:0] ptr);
		return ADDR_W'(int'(lvl) * QUEUE_DEPTH + int'(ptr));
	endfunction

	// Advance a ring pointer, wrapping at the queue depth
	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
		return (int'(ptr) + 1 >= QUEUE_DEPTH) ? '0 : PTR_W'(int'(ptr) + 1);
	endfunction

endpackage

[hdl/mlpq_store.sv]
// Task id storage: one synchronous RAM, one write and one registered read port.
// Depends on mlpq_pkg.
module mlpq_store (
	input  logic                         clk,
	input  mlpq_pkg::mem_req_t           mreq,
	output logic [mlpq_pkg::ID_WIDTH-1:0] rdata
);
	import mlpq_pkg::*;

	logic [ID_WIDTH-1:0] mem [ENTRIES];

	// Write the new task id
	always_ff @(posedge clk) begin
		if (mreq.we) begin
			mem[mreq.waddr] <= mreq.wdata;
		end
	end

	// Read the head entry; the read data is registered
	always_ff @(posedge clk) begin
		if (mreq.re) begin
			rdata <= mem[mreq.raddr];
		end
	end

endmodule

[hdl/mlpq_ctrl.sv]
// Queue control: per-level head, tail and fill, running total, level pick.
// Updates state on each accepted beat and issues the store access. Depends on mlpq_pkg.
module mlpq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  mlpq_pkg::req_t     req,
	output mlpq_pkg::mem_req_t mreq,
	output mlpq_pkg::meta_t    meta
);
	import mlpq_pkg::*;

	logic [PTR_W-1:0]   head_q [NUM_LEVELS];
	logic [PTR_W-1:0]   tail_q [NUM_LEVELS];
	logic [FILL_W-1:0]  fill_q [NUM_LEVELS];
	logic [FILL_W-1:0]  fill_d [NUM_LEVELS];
	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W-1:0] total_d;

	logic             prio_ok;
	logic [LVL_W-1:0] lvl;
	logic             is_add;
	logic             is_take;
	logic             add_ok;
	logic             rem_ok;
	logic             any;
	logic [LVL_W-1:0] pick;

	// Decode the request
	assign prio_ok = (req.priority_req != '0) && (int'(req.priority_req) <= NUM_LEVELS);
	assign lvl     = LVL_W'(int'(req.priority_req) - 1);
	assign is_add  = (req.func == FUNC_ADD);
	assign is_take = (req.func == FUNC_PEEK) || (req.func == FUNC_REMOVE);
	assign add_ok  = is_add && prio_ok && (int'(fill_q[lvl]) < QUEUE_DEPTH);

	// Pick the lowest numbered nonempty level
	always_comb begin
		any  = 1'b0;
		pick = '0;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (fill_q[i] != '0) begin
				any  = 1'b1;
				pick = LVL_W'(i);
			end
		end
	end

	assign rem_ok = (req.func == FUNC_REMOVE) && any;

	// Fill after this beat
	always_comb begin
		for (int i = 0; i < NUM_LEVELS; i++) begin
			fill_d[i] = fill_q[i];
		end
		total_d = total_q;
		if (add_ok) begin
			fill_d[lvl] = fill_q[lvl] + 1'b1;
			total_d     = total_q + 1'b1;
		end else if (rem_ok) begin
			fill_d[pick] = fill_q[pick] - 1'b1;
			total_d      = total_q - 1'b1;
		end
	end

	// Store access
	always_comb begin
		mreq.we    = fire && add_ok;
		mreq.waddr = entry_addr(lvl, tail_q[lvl]);
		mreq.wdata = req.task_id;
		mreq.re    = fire && is_take && any;
		mreq.raddr = entry_addr(pick, head_q[pick]);
	end

	// Result fields known now
	always_comb begin
		meta.found        = is_take && any;
		meta.out_priority = (is_take && any) ? PRIO_W'(int'(pick) + 1) : '0;
		meta.rejected     = is_add && !add_ok;
		meta.is_empty     = (total_d == '0);
		meta.total_count  = TCNT_W'(total_d);
		meta.level_count  = prio_ok ? LCNT_W'(fill_d[lvl]) : '0;
	end

	// Commit the state on an accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
			total_q <= '0;
		end else if (fire) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				fill_q[i] <= fill_d[i];
			end
			total_q <= total_d;
			if (add_ok) begin
				tail_q[lvl] <= bump(tail_q[lvl]);
			end
			if (rem_ok) begin
				head_q[pick] <= bump(head_q[pick]);
			end
		end
	end

endmodule

[hdl/multilevel_priority_queue_core.sv]
// Multilevel strict priority FIFO queue, top level.
// The result beat passes through the read stage register and then the output register.
// No new request is taken while one waits in the read stage for the registered store read.
// A result in the output register overlaps the next request unless rsp_stall holds it.
// Reset clears pointers, fills and counts at once; the task store is not cleared.
// Depends on mlpq_pkg, mlpq_ctrl, mlpq_store.
module multilevel_priority_queue_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  mlpq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output mlpq_pkg::rsp_t rsp
);
	import mlpq_pkg::*;

	logic                fire;
	mem_req_t            mreq;
	meta_t               meta;
	logic [ID_WIDTH-1:0] rdata;

	logic  valid_s1;
	meta_t meta_s1;
	logic  rsp_valid_q;
	rsp_t  rsp_q;

	// Take a beat only when the read stage is free and the output can drain
	assign req_stall = valid_s1 || (rsp_valid_q && rsp_stall);
	assign fire      = req_valid && !req_stall;

	mlpq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req),
		.mreq   (mreq),
		.meta   (meta)
	);

	mlpq_store u_store (
		.clk   (clk),
		.mreq  (mreq),
		.rdata (rdata)
	);

	// Read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= fire;
		end
	end

	// Hold the result fields while the store read completes
	always_ff @(posedge clk) begin
		if (fire) begin
			meta_s1 <= meta;
		end
	end

	// Output valid: set from the read stage, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (valid_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_q.out_task_id  <= meta_s1.found ? TID_W'(rdata) : '0;
			rsp_q.out_priority <= meta_s1.out_priority;
			rsp_q.found        <= meta_s1.found;
			rsp_q.rejected     <= meta_s1.rejected;
			rsp_q.is_empty     <= meta_s1.is_empty;
			rsp_q.total_count  <= meta_s1.total_count;
			rsp_q.level_count  <= meta_s1.level_count;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[hdl/mlpq_checker.sv]
// Port-level checker for the multilevel priority queue, bound to the top level.
// Depends on mlpq_pkg and multilevel_priority_queue_core_macros.svh.
`include "multilevel_priority_queue_core_macros.svh"

module mlpq_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input mlpq_pkg::rsp_t rsp
);
	import mlpq_pkg::*;

	logic acc;
	assign acc = req_valid && !req_stall;

	// An accepted beat blocks the next one and lands after the read stage and output register
	`MLPQ_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, acc, req_stall && !rsp_valid)
	`MLPQ_ASSERT_NOW(a_result_lands, clk, arst_n, acc, ##2 rsp_valid)
	// Empty flag agrees with the total count
	`MLPQ_ASSERT_NOW(a_empty_total, clk, arst_n, rsp_valid, rsp.is_empty == (rsp.total_count == '0))
	// A found task has a level, a rejected add finds nothing
	`MLPQ_ASSERT_NOW(a_found_level, clk, arst_n, rsp_valid, (rsp.found == (rsp.out_priority != '0)) && !(rsp.found && rsp.rejected))

endmodule

bind multilevel_priority_queue_core mlpq_checker u_mlpq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
